// ----- src/strassen_matrix_multiply_assert.svh -----
// ----------------------------------------------------------------------------
// strassen_matrix_multiply_assert
// Assertion macros for the Strassen matrix multiplier.
// ----------------------------------------------------------------------------
`ifndef STRASSEN_MATRIX_MULTIPLY_ASSERT_SVH
`define STRASSEN_MATRIX_MULTIPLY_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SMM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Implication with the consequent checked in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- src/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the Strassen matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;
   localparam int MatrixSize = 4;
   localparam int Cells      = MatrixSize * MatrixSize;
   localparam int IdxW       = $clog2(Cells);
   localparam int RowW       = $clog2(MatrixSize);
   localparam int CntW       = $clog2(Cells + 1);
   localparam int KW         = $clog2(MatrixSize + 1);

   typedef struct packed {
      logic signed [15:0] a_element;
      logic signed [15:0] b_element;
   } req_word_type;

   typedef struct packed {
      logic signed [35:0] c_element;
      logic               last_element;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_READ, ST_MAC, ST_EMIT, ST_WAIT
   } state_type;

   typedef struct packed {
      logic       load;      // store incoming word
      logic       clr_acc;   // clear accumulator, start new element
      logic       mac;       // accumulate current product term
      logic       emit;      // load output register
      logic [IdxW-1:0] wr_idx;
      logic [RowW-1:0] row;
      logic [RowW-1:0] col;
      logic [RowW-1:0] k;
      logic       last;
   } ctl_type;
endpackage

// ----- src/strassen_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// strassen_matrix_multiply
// 4x4 signed matrix multiplier, exact 36-bit product, row-major streaming.
// ----------------------------------------------------------------------------
// Feed N*N words (one A and one B element each, row-major); loading takes one
// word per cycle. After the last word the block produces the N*N product
// elements in row-major order, last_element set on the final one. The product
// is exact, identical to Strassen's result. Each product element goes through
// one shared 16x16 multiplier in these steps: a read-setup step, N
// multiply-accumulate terms, a drain of the read and multiply stages, a
// step to detect the drain and a hand-off step, which waits while the
// receiver stalls. No input is taken while products are computed or handed
// off; loading of the next matrix may start while the final result still
// waits in the output register, which holds a result until taken.
module strassen_matrix_multiply (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  smm_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output smm_pkg::rsp_word_type rsp_data
);
   import smm_pkg::*;
`include "strassen_matrix_multiply_assert.svh"

   ctl_type ctl;

   smm_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .ctl
   );

   smm_datapath u_datapath (
      .clock, .req_word(req_data), .ctl, .out_word(rsp_data)
   );

   // input is taken while a result is waiting only if that result is the last one
   `SMM_ASSERT_IMP(a_no_overlap, req_ready && rsp_valid, rsp_data.last_element, "overlap")
   // a held result does not change
   `SMM_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, $stable(rsp_data), "result changed")
   // loading and emission exclusive
   `SMM_ASSERT_IMP(a_load_emit, ctl.load, !ctl.emit, "load during emit")
endmodule

// ----- src/smm_datapath.sv -----
// ----------------------------------------------------------------------------
// smm_datapath
// Operand stores, shared multiplier and accumulator, output register.
// ----------------------------------------------------------------------------
module smm_datapath (
   input  logic                 clock,
   input  smm_pkg::req_word_type req_word,
   input  smm_pkg::ctl_type     ctl,
   output smm_pkg::rsp_word_type out_word
);
   import smm_pkg::*;

   logic signed [15:0] a_mem [Cells];
   logic signed [15:0] b_mem [Cells];
   logic signed [15:0] a_rd_ff, b_rd_ff;
   logic signed [31:0] prod_ff;
   logic signed [35:0] acc_ff, acc_in;
   logic [IdxW-1:0]    a_addr, b_addr;

   // row-major addresses of A[row][k] and B[k][col]
   assign a_addr = IdxW'({ctl.row, ctl.k});
   assign b_addr = IdxW'({ctl.k, ctl.col});

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_mem[ctl.wr_idx] <= req_word.a_element;
         b_mem[ctl.wr_idx] <= req_word.b_element;
      end
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clr_acc) begin
         acc_in = '0;
      end else if (ctl.mac) begin
         acc_in = acc_ff + 36'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.emit) begin
         out_word.c_element    <= acc_ff;
         out_word.last_element <= ctl.last;
      end
   end
endmodule

// ----- src/smm_control.sv -----
// ----------------------------------------------------------------------------
// smm_control
// Sequencer: loads words, steps the product terms, hands off results.
// ----------------------------------------------------------------------------
module smm_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output smm_pkg::ctl_type ctl
);
   import smm_pkg::*;

   state_type        state_ff, state_in;
   logic [IdxW-1:0]  cnt_ff, cnt_in;     // load index, then element index
   logic [KW-1:0]    k_ff, k_in;         // term issue counter
   logic [1:0]       pipe_ff, pipe_in;   // terms in flight (read, multiply)
   logic             valid_ff, valid_in;
   logic             issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         k_ff     <= '0;
         pipe_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         pipe_ff  <= pipe_in;
         valid_ff <= valid_in;
      end
   end

   assign issue = (state_ff == ST_MAC) && (k_ff < KW'(MatrixSize));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      pipe_in  = {pipe_ff[0], issue};
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == IdxW'(Cells - 1)) state_in = ST_READ;
            end
         end
         ST_READ: begin
            k_in     = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (issue) k_in = k_ff + 1'b1;
            else if (pipe_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!valid_ff || rsp_ready) begin
               valid_in = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = (cnt_ff == IdxW'(Cells - 1)) ? ST_LOAD : ST_READ;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      ctl         = '0;
      ctl.wr_idx  = cnt_ff;
      ctl.row     = cnt_ff[IdxW-1 -: RowW];
      ctl.col     = cnt_ff[RowW-1:0];
      ctl.k       = k_ff[RowW-1:0];
      ctl.last    = (cnt_ff == IdxW'(Cells - 1));
      ctl.mac     = pipe_ff[1];
      case (state_ff)
         ST_LOAD: ctl.load    = req_valid;
         ST_READ: ctl.clr_acc = 1'b1;
         ST_EMIT: ctl.emit    = !valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = valid_ff;
endmodule

// ----- tb/strassen_matrix_multiply_checker.sv -----
// ----------------------------------------------------------------------------
// strassen_matrix_multiply_checker
// Watches both channels, predicts each product matrix and compares words.
// ----------------------------------------------------------------------------
module strassen_matrix_multiply_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  smm_pkg::req_word_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  smm_pkg::rsp_word_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   import smm_pkg::*;

   logic signed [15:0] a_cells [Cells];
   logic signed [15:0] b_cells [Cells];
   int                 loaded;
   rsp_word_type       product_queue [$];

   // plain row-by-column product; equals the Strassen result exactly
   function automatic void push_product();
      longint acc;
      rsp_word_type w;
      for (int r = 0; r < MatrixSize; r++)
         for (int c = 0; c < MatrixSize; c++) begin
            acc = 0;
            for (int k = 0; k < MatrixSize; k++)
               acc += longint'(a_cells[r*MatrixSize+k]) * longint'(b_cells[k*MatrixSize+c]);
            w.c_element    = acc[35:0];
            w.last_element = (r == MatrixSize-1) && (c == MatrixSize-1);
            product_queue.push_back(w);
         end
   endfunction

   assign pending_count = product_queue.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         loaded     <= 0;
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            a_cells[loaded] = req_data.a_element;
            b_cells[loaded] = req_data.b_element;
            if (loaded == Cells-1) begin
               push_product();
               loaded <= 0;
            end else begin
               loaded <= loaded + 1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (product_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected word: c=%0d last=%0b",
                           rsp_data.c_element, rsp_data.last_element);
               fail_count <= fail_count + 1;
            end else begin
               want = product_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected c=%0d last=%0b, got c=%0d last=%0b",
                              want.c_element, want.last_element,
                              rsp_data.c_element, rsp_data.last_element);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- tb/strassen_matrix_multiply_tb.sv -----
// ----------------------------------------------------------------------------
// strassen_matrix_multiply_tb
// Streams matrix pairs into the multiplier with bursty valid and a stalling
// receiver; a checker predicts every product word and counts mismatches.
// ----------------------------------------------------------------------------
module strassen_matrix_multiply_tb;
   import smm_pkg::*;

   localparam int RandomMatrices = 28;     // (28 + 2 directed) * 16 = 480 words
   localparam int CycleLimit     = 400000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   int           fail_count;
   int           pending_count;
   int           cycle_count;
   int           stall_mode;

   strassen_matrix_multiply DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   strassen_matrix_multiply_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // cycle watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: stall pattern switches among always-ready, light and heavy stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // one word: hold valid until taken, then optionally drop it for a gap
   task automatic send_word(input logic [15:0] a, input logic [15:0] b,
                            input bit keep_valid);
      req_valid          <= 1'b1;
      req_data.a_element <= a;
      req_data.b_element <= b;
      do @(posedge clock); while (!req_ready);
      if (!keep_valid)
         req_valid <= 1'b0;
   endtask

   // bursty sender: burst length and gap drawn at random
   int burst_left;
   task automatic send_bursty(input logic [15:0] a, input logic [15:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_word(a, b, 1'b1);
   endtask

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 3)) - 16'd2;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   initial begin
      cycle_count = 0;
      burst_left  = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: most negative times itself (largest positive product)
      for (int i = 0; i < Cells; i++)
         send_word(16'h8000, 16'h8000, 1'b1);
      // most negative against most positive, identity-like mix
      for (int i = 0; i < Cells; i++)
         send_word(16'h8000, (i % (MatrixSize+1) == 0) ? 16'h7FFF : 16'h0000,
                   i != Cells-1);

      // hold off until every product word is back
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      for (int m = 0; m < RandomMatrices; m++)
         for (int i = 0; i < Cells; i++)
            send_bursty(rand_elem(), rand_elem());
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
